/* src/lfuc_pkg.sv */
// Shared constants, types and command/status structs for the LFU cache.
package lfuc_pkg;

  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;
  localparam int DATA_W     = 32;
  localparam int CAP_W      = 5;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W      = $clog2(ENTRIES + 1);
  localparam int CMP_W      = (CAP_W > OCC_W) ? CAP_W : OCC_W;
  localparam int LEAVES     = 1 << IDX_W;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic [COUNT_BITS-1:0]      count_t;
  typedef logic signed [DATA_W-1:0]   word_t;
  typedef logic [CAP_W-1:0]           cap_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
  } lfuc_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } lfuc_sts_t;

endpackage

/* src/lfuc_if.sv */
// Request, response and configuration channel interfaces.
interface lfuc_req_if;
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic signed [31:0]     key;
  logic signed [31:0]     value;
  modport source (output valid, output req_type, output key, output value, input ready);
  modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface lfuc_rsp_if;
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic signed [31:0]     read_value;
  logic                   evicted;
  logic signed [31:0]     evicted_key;
  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

interface lfuc_cfg_if;
  logic             valid;
  logic             ready;
  logic [4:0]       capacity_limit;
  modport source (output valid, output capacity_limit, input ready);
  modport sink   (input valid, input capacity_limit, output ready);
endinterface

/* src/lfuc_dp.sv */
// Datapath: entry store, key match, victim select tree, recency update, result register.
module lfuc_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lfuc_pkg::lfuc_cmd_t  cmd,
  output lfuc_pkg::lfuc_sts_t  sts,
  input  logic                 in_req_type,
  input  lfuc_pkg::word_t      in_key,
  input  lfuc_pkg::word_t      in_value,
  input  logic                 cfg_valid,
  input  lfuc_pkg::cap_t       cfg_capacity_limit,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output lfuc_pkg::word_t      out_read_value,
  output logic                 out_evicted,
  output lfuc_pkg::word_t      out_evicted_key
);
  import lfuc_pkg::*;

  // configuration and occupancy
  cap_t               cap_r;
  logic [OCC_W-1:0]   occ_r, occ_nxt;

  // entry store
  logic [ENTRIES-1:0] valid_r;
  word_t              key_mem_r [ENTRIES];
  word_t              val_mem_r [ENTRIES];
  count_t             cnt_r     [ENTRIES];
  idx_t               rank_r    [ENTRIES];
  idx_t               rank_nxt  [ENTRIES];

  // captured request
  logic               req_type_r;
  word_t              key_r;
  word_t              value_r;

  // lookup stage
  logic               lk_en_r, lk_hit_r, lk_full_r, lk_free_ok_r, lk_vic_ok_r;
  idx_t               lk_found_r, lk_free_r, lk_vic_r;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_evicted_r;
  word_t              out_read_value_r, out_evicted_key_r;

  // lookup logic
  logic [ENTRIES-1:0] match;
  logic               hit_c, free_ok_c, en_c, full_c;
  idx_t               found_c, free_c;
  logic [CMP_W-1:0]   cap_ext, cap_eff;

  // victim tree, heap layout: node n combines 2n and 2n+1
  logic               nd_ok   [2*LEAVES];
  idx_t               nd_idx  [2*LEAVES];
  count_t             nd_cnt  [2*LEAVES];
  idx_t               nd_rank [2*LEAVES];
  logic               take_right;

  // commit logic
  logic               do_hit, do_ins, do_evict, ins_ok, touch;
  idx_t               slot, touch_idx, touch_rank;
  logic               rsp_hit, rsp_evicted;
  word_t              rsp_read_value, rsp_evicted_key;

  always_comb begin
    found_c = '0;
    free_c  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid_r[i] && (key_mem_r[i] == key_r);
      if (match[i]) begin
        found_c = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_c = IDX_W'(i);
      end
    end
    hit_c     = |match;
    free_ok_c = ~&valid_r;
    cap_ext   = CMP_W'(cap_r);
    cap_eff   = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
    en_c      = (cap_eff != '0);
    full_c    = (CMP_W'(occ_r) >= cap_eff);
  end

  // lowest count wins; on equal counts the older (larger rank) wins
  always_comb begin
    take_right = 1'b0;
    for (int n = 0; n < 2 * LEAVES; n++) begin
      nd_ok[n]   = 1'b0;
      nd_idx[n]  = '0;
      nd_cnt[n]  = '0;
      nd_rank[n] = '0;
    end
    for (int i = 0; i < LEAVES; i++) begin
      if (i < ENTRIES) begin
        nd_ok[LEAVES+i]   = valid_r[i];
        nd_idx[LEAVES+i]  = IDX_W'(i);
        nd_cnt[LEAVES+i]  = cnt_r[i];
        nd_rank[LEAVES+i] = rank_r[i];
      end
    end
    for (int n = LEAVES - 1; n >= 1; n--) begin
      take_right = nd_ok[2*n+1] &&
                   (!nd_ok[2*n] ||
                    (nd_cnt[2*n+1] < nd_cnt[2*n]) ||
                    ((nd_cnt[2*n+1] == nd_cnt[2*n]) && (nd_rank[2*n+1] > nd_rank[2*n])));
      nd_ok[n]   = nd_ok[2*n] | nd_ok[2*n+1];
      nd_idx[n]  = take_right ? nd_idx[2*n+1]  : nd_idx[2*n];
      nd_cnt[n]  = take_right ? nd_cnt[2*n+1]  : nd_cnt[2*n];
      nd_rank[n] = take_right ? nd_rank[2*n+1] : nd_rank[2*n];
    end
  end

  always_comb begin
    do_hit     = lk_en_r & lk_hit_r;
    do_ins     = lk_en_r & ~lk_hit_r & (req_type_r == REQ_PUT);
    do_evict   = do_ins & lk_full_r & lk_vic_ok_r;
    slot       = do_evict ? lk_vic_r : lk_free_r;
    ins_ok     = do_evict | (do_ins & lk_free_ok_r);
    touch      = do_hit | ins_ok;
    touch_idx  = do_hit ? lk_found_r : slot;
    touch_rank = rank_r[touch_idx];
    for (int j = 0; j < ENTRIES; j++) begin
      if (IDX_W'(j) == touch_idx) begin
        rank_nxt[j] = '0;
      end else if (rank_r[j] < touch_rank) begin
        rank_nxt[j] = rank_r[j] + 1'b1;
      end else begin
        rank_nxt[j] = rank_r[j];
      end
    end
    occ_nxt = occ_r;
    if (ins_ok && !do_evict) begin
      occ_nxt = occ_r + 1'b1;
    end
    rsp_hit         = do_hit;
    rsp_read_value  = (do_hit && (req_type_r == REQ_GET)) ? val_mem_r[lk_found_r] : MISS_VALUE;
    rsp_evicted     = do_evict;
    rsp_evicted_key = do_evict ? key_mem_r[lk_vic_r] : '0;
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= IDX_W'(i);
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        cap_r <= cfg_capacity_limit;
      end
      if (cmd.commit) begin
        occ_r <= occ_nxt;
        if (ins_ok) begin
          valid_r[slot] <= 1'b1;
        end
        if (touch) begin
          rank_r <= rank_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_r <= in_req_type;
      key_r      <= in_key;
      value_r    <= in_value;
    end
    if (cmd.lookup) begin
      lk_en_r      <= en_c;
      lk_hit_r     <= hit_c;
      lk_found_r   <= found_c;
      lk_free_r    <= free_c;
      lk_free_ok_r <= free_ok_c;
      lk_full_r    <= full_c;
      lk_vic_r     <= nd_idx[1];
      lk_vic_ok_r  <= nd_ok[1];
    end
    if (cmd.commit) begin
      out_hit_r         <= rsp_hit;
      out_read_value_r  <= rsp_read_value;
      out_evicted_r     <= rsp_evicted;
      out_evicted_key_r <= rsp_evicted_key;
      if (do_hit) begin
        if (req_type_r == REQ_PUT) begin
          val_mem_r[lk_found_r] <= value_r;
        end
        // saturate at the top count
        if (cnt_r[lk_found_r] != '1) begin
          cnt_r[lk_found_r] <= cnt_r[lk_found_r] + 1'b1;
        end
      end
      if (ins_ok) begin
        key_mem_r[slot] <= key_r;
        val_mem_r[slot] <= value_r;
        cnt_r[slot]     <= COUNT_BITS'(1);
      end
    end
  end

  assign sts.out_blocked  = out_valid_r & ~out_ready;
  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_read_value   = out_read_value_r;
  assign out_evicted      = out_evicted_r;
  assign out_evicted_key  = out_evicted_key_r;

endmodule

/* src/lfuc_ctrl.sv */
// Controller: sequences capture, lookup and commit of one request at a time.
module lfuc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lfuc_pkg::lfuc_sts_t  sts,
  output lfuc_pkg::lfuc_cmd_t  cmd
);
  import lfuc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_UPD  = 3'b100
  } lfuc_state_t;

  lfuc_state_t state_r, state_nxt;

  always_comb begin
    in_ready    = (state_r == ST_IDLE);
    cmd.capture = in_valid & in_ready;
    cmd.lookup  = (state_r == ST_LOOK);
    // hold the update until the result register is free
    cmd.commit  = (state_r == ST_UPD) & ~sts.out_blocked;
    state_nxt   = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.capture) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (cmd.commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* src/lfu_cache_with_lru_tiebreak_unit.sv */
// Fully associative 16-entry key/value cache with LFU replacement and LRU tie-break.
// Each request (get or put) returns one response: hit flag, read value (-1 unless a get
// hits), and the key of any entry evicted to make room. A request passes through capture,
// parallel key match plus victim tree, and update; the next request is taken the
// cycle after the update, while the previous response may still wait in the output
// register, so the unit handles one request at a time, and the update waits while the
// output register is still full. A capacity limit of 0 disables the cache; limits above
// 16 act as 16. The capacity limit is written through the configuration channel, which
// is always ready, and should only be written while no request is in flight.
module lfu_cache_with_lru_tiebreak_unit (
  input  logic        clk,
  input  logic        rst_n,
  lfuc_req_if.sink    in_req,
  lfuc_rsp_if.source  out_rsp,
  lfuc_cfg_if.sink    cfg_wr
);
  import lfuc_pkg::*;

  lfuc_cmd_t cmd;
  lfuc_sts_t sts;
  logic      req_ready;

  lfuc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (req_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfuc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_req_type        (in_req.req_type),
    .in_key             (in_req.key),
    .in_value           (in_req.value),
    .cfg_valid          (cfg_wr.valid),
    .cfg_capacity_limit (cfg_wr.capacity_limit),
    .out_valid          (out_rsp.valid),
    .out_ready          (out_rsp.ready),
    .out_hit            (out_rsp.hit),
    .out_read_value     (out_rsp.read_value),
    .out_evicted        (out_rsp.evicted),
    .out_evicted_key    (out_rsp.evicted_key)
  );

  assign in_req.ready = req_ready;
  assign cfg_wr.ready = 1'b1;

endmodule

/* tb/lfuc_checker.sv */
// Response checker for the LFU cache: mirrors the cache state and scores every response.
`timescale 1ns / 100ps
module lfuc_checker (
  input  logic        clk,
  input  logic        rst_n,
  lfuc_req_if         req,
  lfuc_rsp_if         rsp,
  lfuc_cfg_if         cfg,
  output int unsigned rsp_pending,
  output int unsigned fail_count
);
  import lfuc_pkg::*;

  typedef struct packed {
    logic  hit;
    word_t read_value;
    logic  evicted;
    word_t evicted_key;
  } cache_rsp_t;

  logic       slot_valid [ENTRIES];
  word_t      slot_key   [ENTRIES];
  word_t      slot_val   [ENTRIES];
  count_t     slot_uses  [ENTRIES];
  idx_t       slot_age   [ENTRIES];
  cap_t       cap_reg;
  cache_rsp_t rsp_q [$];
  cache_rsp_t want;

  task automatic report_mismatch(string what, word_t got, word_t exp_val);
    if (fail_count < 50) begin
      $display("ERROR %0t: %0s got %h want %h", $realtime, what, got, exp_val);
    end
    fail_count++;
  endtask

  // Move a slot to most recent; age everything that was newer than it.
  function automatic void make_newest(int s);
    idx_t r;
    r = slot_age[s];
    for (int j = 0; j < ENTRIES; j++) begin
      if (slot_age[j] < r) slot_age[j]++;
    end
    slot_age[s] = '0;
  endfunction

  function automatic cache_rsp_t cache_lookup(logic is_put, word_t k, word_t v);
    cache_rsp_t r;
    int         lim;
    int         occ;
    int         found;
    int         slot;
    bit         have;
    bit         slot_ok;
    r.hit         = 1'b0;
    r.read_value  = MISS_VALUE;
    r.evicted     = 1'b0;
    r.evicted_key = '0;
    lim     = (cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg);
    occ     = 0;
    found   = 0;
    slot    = 0;
    have    = 1'b0;
    slot_ok = 1'b0;
    if (lim != 0) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_valid[i]) begin
          occ++;
          if (!have && slot_key[i] == k) begin
            have  = 1'b1;
            found = i;
          end
        end
      end
      if (have) begin
        r.hit = 1'b1;
        if (is_put == REQ_PUT) slot_val[found] = v;
        else r.read_value = slot_val[found];
        if (slot_uses[found] != '1) slot_uses[found]++;
        make_newest(found);
      end else if (is_put == REQ_PUT) begin
        if (occ >= lim) begin
          // Victim: lowest use count, oldest among equals.
          for (int i = 0; i < ENTRIES; i++) begin
            if (!slot_valid[i]) continue;
            if (!slot_ok || slot_uses[i] < slot_uses[slot] ||
                (slot_uses[i] == slot_uses[slot] && slot_age[i] > slot_age[slot])) begin
              slot    = i;
              slot_ok = 1'b1;
            end
          end
          if (slot_ok) begin
            r.evicted         = 1'b1;
            r.evicted_key     = slot_key[slot];
            slot_valid[slot]  = 1'b0;
          end
        end
        if (!slot_ok) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (!slot_valid[i]) begin
              slot    = i;
              slot_ok = 1'b1;
              break;
            end
          end
        end
        if (slot_ok) begin
          slot_valid[slot] = 1'b1;
          slot_key[slot]   = k;
          slot_val[slot]   = v;
          slot_uses[slot]  = count_t'(1);
          make_newest(slot);
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_key[i]   = '0;
        slot_val[i]   = '0;
        slot_uses[i]  = '0;
        slot_age[i]   = idx_t'(i);
      end
      cap_reg = CAP_RESET;
      fail_count = 0;
      rsp_q.delete();
    end else begin
      // Score the response first: it belongs to an earlier request.
      if (rsp.valid && rsp.ready) begin
        if (rsp_q.size() == 0) begin
          report_mismatch("response with no request outstanding", '0, '0);
        end else begin
          want = rsp_q.pop_front();
          if (rsp.hit !== want.hit)
            report_mismatch("hit", word_t'(rsp.hit), word_t'(want.hit));
          if (rsp.read_value !== want.read_value)
            report_mismatch("read_value", rsp.read_value, want.read_value);
          if (rsp.evicted !== want.evicted)
            report_mismatch("evicted", word_t'(rsp.evicted), word_t'(want.evicted));
          if (rsp.evicted_key !== want.evicted_key)
            report_mismatch("evicted_key", rsp.evicted_key, want.evicted_key);
        end
      end
      if (cfg.valid && cfg.ready) cap_reg = cfg.capacity_limit;
      if (req.valid && req.ready) begin
        rsp_q.push_back(cache_lookup(req.req_type, req.key, req.value));
      end
    end
    rsp_pending = rsp_q.size();
  end

endmodule

/* tb/tb_lfu_cache_with_lru_tiebreak_unit.sv */
// Top of the LFU cache testbench: clock, reset, request and config stimulus, verdict.
`timescale 1ns / 100ps
module tb_lfu_cache_with_lru_tiebreak_unit;
  import lfuc_pkg::*;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOT_USES     = 64;
  localparam int PHASE_ITEMS  = 160;
  localparam int POOL_MAX     = 32;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned rsp_pending;
  int unsigned fail_count;
  int unsigned idle_pct    = 26;
  bit          pressure_on = 1'b0;
  int unsigned hold_cnt    = 0;
  int unsigned cycle_cnt   = 0;
  word_t       key_pool [POOL_MAX];
  int          pool_len  = 4;
  cap_t        phase_caps [10] = '{5'd16, 5'd4, 5'd31, 5'd1, 5'd0,
                                   5'd9, 5'd17, 5'd2, 5'd16, 5'd12};

  lfuc_req_if req_ch ();
  lfuc_rsp_if rsp_ch ();
  lfuc_cfg_if cfg_ch ();

  lfu_cache_with_lru_tiebreak_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch),
    .cfg_wr  (cfg_ch)
  );

  lfuc_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg         (cfg_ch),
    .rsp_pending (rsp_pending),
    .fail_count  (fail_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Response side: random back-pressure, plus one long hold-off when asked.
  always @(negedge clk) begin
    if (pressure_on && hold_cnt < HOLD_CYCLES) begin
      rsp_ch.ready <= 1'b0;
      hold_cnt++;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic send_req(logic is_put, word_t k, word_t v);
    int gap;
    gap = 0;
    while (gap < 6 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= is_put;
    req_ch.key      <= k;
    req_ch.value    <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every response is back and the pipe is empty.
  task automatic quiesce();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (rsp_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cap(cap_t c);
    quiesce();
    cfg_ch.valid          <= 1'b1;
    cfg_ch.capacity_limit <= c;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_idle(int unsigned pct);
    @(posedge clk);
    idle_pct = pct;
  endtask

  function automatic word_t pick_key();
    if ($urandom_range(99) < 88) return key_pool[$urandom_range(pool_len - 1)];
    return word_t'($urandom);
  endfunction

  task automatic random_phase(int n, int put_pct);
    logic is_put;
    for (int i = 0; i < n; i++) begin
      is_put = ($urandom_range(99) < put_pct) ? REQ_PUT : REQ_GET;
      send_req(is_put, pick_key(), word_t'($urandom));
    end
  endtask

  initial begin
    int lim;
    word_t hot_key;
    req_ch.valid          = 1'b0;
    req_ch.req_type       = REQ_GET;
    req_ch.key            = '0;
    req_ch.value          = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.capacity_limit = '0;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_MAX; i++) key_pool[i] = word_t'($urandom);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty miss, extreme keys and values, update, then limit corners.
    send_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    send_req(REQ_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_req(REQ_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_req(REQ_PUT, 32'h0000_0000, 32'h0000_0000);
    send_req(REQ_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_req(REQ_GET, 32'h8000_0000, 32'hffff_ffff);
    send_req(REQ_GET, 32'h7fff_ffff, 32'h0000_0000);
    send_req(REQ_GET, 32'hffff_ffff, 32'h5a5a_5a5a);
    send_req(REQ_PUT, 32'h0000_0000, 32'h1234_5678);
    send_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    // Limit below occupancy: each new key evicts exactly one.
    write_cap(5'd3);
    send_req(REQ_PUT, 32'h0000_0001, 32'h0000_0001);
    send_req(REQ_PUT, 32'h0000_0002, 32'h0000_0002);
    send_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    send_req(REQ_PUT, 32'hffff_ffff, 32'h0bad_cafe);
    // Disabled: everything misses, nothing changes.
    write_cap(5'd0);
    send_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    send_req(REQ_PUT, 32'h0000_0005, 32'h0000_0005);
    send_req(REQ_PUT, 32'h0000_0000, 32'h7777_7777);
    // Limit above the entry count acts as full size.
    write_cap(5'd31);
    send_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    send_req(REQ_GET, 32'h0000_0005, 32'h0000_0000);

    for (int p = 0; p < 10; p++) begin
      write_cap(phase_caps[p]);
      lim = (phase_caps[p] > ENTRIES) ? ENTRIES : int'(phase_caps[p]);
      pool_len = lim + 2 + $urandom_range(6);
      if (pool_len > POOL_MAX) pool_len = POOL_MAX;
      if (p == 0) begin
        @(posedge clk);
        pressure_on = 1'b1;
      end
      random_phase(PHASE_ITEMS, 30 + $urandom_range(30));
    end

    // Hammer one entry back to back with no idling on either side.
    write_cap(5'd2);
    set_idle(0);
    hot_key = word_t'($urandom);
    send_req(REQ_PUT, hot_key, word_t'($urandom));
    for (int i = 0; i < HOT_USES; i++) begin
      if ($urandom_range(15) == 0) send_req(REQ_PUT, hot_key, word_t'($urandom));
      else send_req(REQ_GET, hot_key, word_t'($urandom));
    end
    send_req(REQ_PUT, ~hot_key, 32'h0000_1111);
    send_req(REQ_GET, ~hot_key, 32'h0000_0000);
    send_req(REQ_PUT, hot_key ^ 32'h0000_0001, 32'h0000_2222);
    send_req(REQ_GET, hot_key, 32'h0000_0000);
    send_req(REQ_GET, ~hot_key, 32'h0000_0000);
    set_idle(26);

    quiesce();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
